// ===== rtl/core/amdfs_pkg.sv =====
// Shared constants, command codes and status types for the adjacency-matrix DFS block.
package amdfs_pkg;

  // Fixed field widths of the external interface
  localparam int VERTEX_W = 6;   // vertex_a / vertex_b
  localparam int COUNT_W  = 7;   // vertex_count, visited_vertex

  localparam int DEF_MAX_VERTICES = 64;

  // vertex_count after reset
  localparam logic [COUNT_W-1:0] CFG_RESET = 7'd64;

  // command codes
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_WALK = 1'b1;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;   // adjacency clear sweep in progress
  } back_status_t;

endpackage

// ===== rtl/core/adjacency_matrix_dfs.sv =====
// Top level of the adjacency-matrix depth-first walk engine.
//
// Keeps an undirected graph of up to MAX_VERTICES vertices as one bit per
// vertex pair in an on-chip RAM and answers walk commands with the vertices
// of a depth-first search from vertex 0, one-based, in visit order, the last
// one flagged with out_last_of_walk. After reset the adjacency RAM is swept
// to zero, one bit a cycle, over all 2^(2*clog2(MAX_VERTICES)) bits (4096 at
// 64 vertices); in_ready stays low during the sweep, config writes are taken.
// A front end classifies each command (an edge that is a self loop or names
// a vertex at or beyond the live count is dropped) and parks it in a
// two-entry queue; the back end executes from the queue, so commands keep
// flowing in while a walk runs. The back end writes an edge as it pops the
// command in its idle state. A walk tests each adjacency bit as a read issue
// and then a check (limited by the single registered read port of the RAM),
// with a further step per vertex visited and per stack pop, plus start and
// close steps; it ends early once all live vertices are reached.
// The newest visit is held back until the walk knows whether it is the last,
// and results leave through an output register, so the search keeps going
// while one result waits for out_ready and stalls at the next visit after it.
// cfg_vertex_count sets the live vertex count (0 acts as 1, values above
// MAX_VERTICES act as MAX_VERTICES); write it only while the block is idle.
module adjacency_matrix_dfs
  import amdfs_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                clk,
  input  logic                rst_n,
  // command transfers
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [VERTEX_W-1:0] in_vertex_a,
  input  logic [VERTEX_W-1:0] in_vertex_b,
  // result transfers
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  out_visited_vertex,
  output logic                out_last_of_walk,
  // config transfers
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_vertex_count
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int QW = 2 * IW + 1;   // command bit + pair address

  logic [COUNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic [CW-1:0]      n_live;
  back_status_t       status;
  logic               q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]      q_in, q_out;

  // config register is always writable
  assign cfg_ready        = 1'b1;
  assign vertex_count_nxt = (cfg_valid && cfg_ready) ? cfg_vertex_count : vertex_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= CFG_RESET;
    end else begin
      vertex_count_r <= vertex_count_nxt;
    end
  end

  // clamp the programmed count into 1..MAX_VERTICES
  always_comb begin
    if (vertex_count_r == '0) begin
      n_live = CW'(1);
    end else if (vertex_count_r > COUNT_W'(MAX_VERTICES)) begin
      n_live = CW'(MAX_VERTICES);
    end else begin
      n_live = vertex_count_r[CW-1:0];
    end
  end

  amdfs_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .n_live      (n_live),
    .status      (status),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  amdfs_fifo #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  amdfs_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .n_live             (n_live),
    .q_valid            (q_valid),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_visited_vertex (out_visited_vertex),
    .out_last_of_walk   (out_last_of_walk)
  );

endmodule

// ===== rtl/core/amdfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module amdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/amdfs_fifo.sv =====
// Two-entry command queue between the front end and the back end.
module amdfs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/amdfs_front.sv =====
// Front end: accepts commands, drops ignored edges, queues edge writes and walks.
module amdfs_front
  import amdfs_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic [VERTEX_W-1:0]                    in_vertex_a,
  input  logic [VERTEX_W-1:0]                    in_vertex_b,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]      n_live,
  input  back_status_t                           status,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [2*$clog2(MAX_VERTICES):0]        q_data
);

  localparam int IW = $clog2(MAX_VERTICES);

  logic          accept;
  logic          edge_ok;
  logic [IW-1:0] a_idx, b_idx, lo, hi;

  assign in_ready = !q_full && !status.clearing;
  assign accept   = in_valid && in_ready;

  assign a_idx = in_vertex_a[IW-1:0];
  assign b_idx = in_vertex_b[IW-1:0];

  // self loops and endpoints beyond the live count never reach the store
  assign edge_ok = (in_vertex_a != in_vertex_b)
                && (COUNT_W'(in_vertex_a) < COUNT_W'(n_live))
                && (COUNT_W'(in_vertex_b) < COUNT_W'(n_live));

  assign lo = (a_idx < b_idx) ? a_idx : b_idx;
  assign hi = (a_idx < b_idx) ? b_idx : a_idx;

  assign q_push = accept && ((in_command == CMD_WALK) || edge_ok);
  assign q_data = {in_command, lo, hi};

endmodule

// ===== rtl/core/amdfs_back.sv =====
// Back end: adjacency store, clear sweep, edge writes and the DFS sequencer.
module amdfs_back
  import amdfs_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]      n_live,
  input  logic                                   q_valid,
  input  logic [2*$clog2(MAX_VERTICES):0]        q_data,
  output logic                                   q_pop,
  output back_status_t                           status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [COUNT_W-1:0]                     out_visited_vertex,
  output logic                                   out_last_of_walk
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = 2 * IW;
  localparam int SW = IW + CW;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_TEST, S_VISIT, S_POP, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           depth_r, depth_nxt;
  logic [IW-1:0]           top_v_r, top_v_nxt;
  logic [CW-1:0]           top_pos_r, top_pos_nxt;
  logic [IW-1:0]           cand_r, cand_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [IW-1:0]           pend_vertex_r, pend_vertex_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]      out_vertex_r, out_vertex_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    adj_we, adj_wdata, adj_rdata;
  logic [AW-1:0]           adj_waddr, adj_raddr;
  logic                    stk_we;
  logic [IW-1:0]           stk_waddr, stk_raddr;
  logic [SW-1:0]           stk_wdata, stk_rdata;

  logic                    q_walk;
  logic [AW-1:0]           q_addr;
  logic [IW-1:0]           scan_v, lo, hi;
  logic [CW-1:0]           depth_m1, depth_m2;
  logic                    out_free;

  assign q_walk   = q_data[AW];
  assign q_addr   = q_data[AW-1:0];
  assign scan_v   = top_pos_r[IW-1:0];
  assign lo       = (top_v_r < scan_v) ? top_v_r : scan_v;
  assign hi       = (top_v_r < scan_v) ? scan_v : top_v_r;
  assign depth_m1 = depth_r - CW'(1);
  assign depth_m2 = depth_r - CW'(2);
  assign out_free = !out_valid_r || out_ready;

  assign status.clearing   = (state_r == S_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_visited_vertex = out_vertex_r;
  assign out_last_of_walk   = out_last_r;

  // one bit per ordered pair {lo,hi}; the diagonal is never set
  amdfs_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // entries below the top of stack; the top lives in top_v_r / top_pos_r
  amdfs_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    visited_nxt     = visited_r;
    count_nxt       = count_r;
    depth_nxt       = depth_r;
    top_v_nxt       = top_v_r;
    top_pos_nxt     = top_pos_r;
    cand_nxt        = cand_r;
    pend_valid_nxt  = pend_valid_r;
    pend_vertex_nxt = pend_vertex_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_vertex_nxt  = out_vertex_r;
    out_last_nxt    = out_last_r;

    q_pop     = 1'b0;
    adj_we    = 1'b0;
    adj_waddr = clr_addr_r;
    adj_wdata = 1'b0;
    adj_raddr = {lo, hi};
    stk_we    = 1'b0;
    stk_waddr = depth_m1[IW-1:0];
    stk_wdata = {top_v_r, top_pos_r};
    stk_raddr = depth_m2[IW-1:0];

    case (state_r)
      S_CLEAR: begin
        adj_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_walk == CMD_WALK) begin
            // vertex 0 is visited first and held as the pending result
            visited_nxt     = MAX_VERTICES'(1);
            count_nxt       = CW'(1);
            depth_nxt       = CW'(1);
            top_v_nxt       = '0;
            top_pos_nxt     = '0;
            pend_valid_nxt  = 1'b1;
            pend_vertex_nxt = '0;
            state_nxt       = S_SCAN;
          end else begin
            adj_we    = 1'b1;
            adj_waddr = q_addr;
            adj_wdata = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (count_r >= n_live) begin
          state_nxt = S_DONE;
        end else if (top_pos_r >= n_live) begin
          if (depth_r == CW'(1)) begin
            depth_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP;
          end
        end else begin
          top_pos_nxt = top_pos_r + CW'(1);
          cand_nxt    = scan_v;
          state_nxt   = S_TEST;
        end
      end
      S_TEST: begin
        if (adj_rdata && !visited_r[cand_r]) begin
          state_nxt = S_VISIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_VISIT: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_vertex_nxt = COUNT_W'(pend_vertex_r) + COUNT_W'(1);
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt      = 1'b1;
          pend_vertex_nxt     = cand_r;
          visited_nxt[cand_r] = 1'b1;
          count_nxt           = count_r + CW'(1);
          stk_we              = 1'b1;
          top_v_nxt           = cand_r;
          top_pos_nxt         = '0;
          depth_nxt           = depth_r + CW'(1);
          state_nxt           = S_SCAN;
        end
      end
      S_POP: begin
        top_v_nxt   = stk_rdata[SW-1:CW];
        top_pos_nxt = stk_rdata[CW-1:0];
        depth_nxt   = depth_m1;
        state_nxt   = S_SCAN;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = COUNT_W'(pend_vertex_r) + COUNT_W'(1);
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      visited_r    <= '0;
      count_r      <= '0;
      depth_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      visited_r    <= visited_nxt;
      count_r      <= count_nxt;
      depth_r      <= depth_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    top_v_r       <= top_v_nxt;
    top_pos_r     <= top_pos_nxt;
    cand_r        <= cand_nxt;
    pend_vertex_r <= pend_vertex_nxt;
    out_vertex_r  <= out_vertex_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

// ===== rtl/core/amdfs_checker.sv =====
// Port-level checker for the DFS block, bound to the top level.
module amdfs_checker
  import amdfs_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_command,
  input logic [VERTEX_W-1:0] in_vertex_a,
  input logic [VERTEX_W-1:0] in_vertex_b,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COUNT_W-1:0]  out_visited_vertex,
  input logic                out_last_of_walk,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [COUNT_W-1:0]  cfg_vertex_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visited_vertex)
                                && $stable(out_last_of_walk))
    else $error("result changed while stalled");

  // emitted ids are one-based and within the vertex range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_visited_vertex != '0
                  && out_visited_vertex <= COUNT_W'(MAX_VERTICES))
    else $error("visited vertex out of range");

  // clear sweep blocks commands right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("command accepted during clear sweep");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adjacency_matrix_dfs amdfs_checker #(.MAX_VERTICES(MAX_VERTICES)) u_amdfs_checker (.*);

// ===== tb/sv/dfs_visit_checker.sv =====
// Checker for the depth-first walk engine: mirrors the graph, predicts visit order, compares.
`timescale 1ns / 1ps

module dfs_visit_checker
  import amdfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_command,
  input  logic [VERTEX_W-1:0] in_vertex_a,
  input  logic [VERTEX_W-1:0] in_vertex_b,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COUNT_W-1:0] out_visited_vertex,
  input  logic               out_last_of_walk,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_vertex_count,
  output int                 mismatch_count,
  output int                 visits_pending,
  output int                 visits_checked
);

  localparam int MAXV = DEF_MAX_VERTICES;

  typedef struct packed {
    logic [COUNT_W-1:0] vertex;
    logic               last;
  } visit_t;

  // symmetric copy of the graph, diagonal never set
  logic [MAXV-1:0]    adj [MAXV];
  logic [COUNT_W-1:0] count_raw;
  visit_t             expected_visits [$];
  int                 fail_tally = 0;
  int                 checked_tally = 0;

  function automatic int live_vertices(input logic [COUNT_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > MAXV) return MAXV;
    return int'(raw);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_tally++;
    $display("[%0t] walk result mismatch: %s, got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic apply_edge(input int a, input int b);
    int n;
    n = live_vertices(count_raw);
    if (a != b && a < n && b < n) begin
      adj[a][b] = 1'b1;
      adj[b][a] = 1'b1;
    end
  endtask

  // DFS from vertex 0, neighbors in ascending order, early exit once all are seen
  task automatic predict_walk();
    logic [MAXV-1:0] seen;
    int     vstack [MAXV];
    int     scan [MAXV];
    int     order [MAXV];
    int     depth, found, n, v, pos;
    visit_t item;
    n        = live_vertices(count_raw);
    seen     = '0;
    seen[0]  = 1'b1;
    order[0] = 0;
    vstack[0] = 0;
    scan[0]  = 0;
    depth    = 1;
    found    = 1;
    while (depth > 0 && found < n) begin
      v   = vstack[depth-1];
      pos = scan[depth-1];
      if (pos >= n) begin
        depth--;
      end else begin
        scan[depth-1] = pos + 1;
        if (adj[v][pos] && !seen[pos]) begin
          seen[pos]     = 1'b1;
          order[found]  = pos;
          vstack[depth] = pos;
          scan[depth]   = 0;
          depth++;
          found++;
        end
      end
    end
    for (int i = 0; i < found; i++) begin
      item.vertex = COUNT_W'(order[i] + 1);
      item.last   = (i == found - 1);
      expected_visits.push_back(item);
    end
  endtask

  task automatic check_visit();
    visit_t want;
    if (expected_visits.size() == 0) begin
      report_mismatch("visit with no walk outstanding", int'(out_visited_vertex), 0);
    end else begin
      want = expected_visits.pop_front();
      if (out_visited_vertex !== want.vertex)
        report_mismatch("visited_vertex", int'(out_visited_vertex), int'(want.vertex));
      if (out_last_of_walk !== want.last)
        report_mismatch("last_of_walk", int'(out_last_of_walk), int'(want.last));
    end
    checked_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAXV; i++) adj[i] = '0;
      count_raw = CFG_RESET;
      expected_visits.delete();
    end else begin
      if (cfg_valid && cfg_ready) count_raw = cfg_vertex_count;
      if (in_valid && in_ready) begin
        if (in_command == CMD_WALK) predict_walk();
        else apply_edge(int'(in_vertex_a), int'(in_vertex_b));
      end
      if (out_valid && out_ready) check_visit();
    end
    mismatch_count <= fail_tally;
    visits_pending <= expected_visits.size();
    visits_checked <= checked_tally;
  end

endmodule

// ===== tb/sv/tb_adjacency_matrix_dfs.sv =====
// Top of the depth-first walk engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_adjacency_matrix_dfs;
  import amdfs_pkg::*;

  // Even if all ~300 transfers were worst-case walks at 64 vertices with their
  // results stalled, the run stays well below this.
  localparam int unsigned LIMIT_CYCLES = 10_000_000;
  localparam int          SETTLE       = 64;   // covers an edge still queued behind a walk
  localparam int          HOLD_CYCLES  = 600;  // long output back-pressure stretch
  localparam int          MAXV         = DEF_MAX_VERTICES;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_command;
  logic [VERTEX_W-1:0] in_vertex_a;
  logic [VERTEX_W-1:0] in_vertex_b;
  logic               out_valid;
  logic               out_ready;
  logic [COUNT_W-1:0] out_visited_vertex;
  logic               out_last_of_walk;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_vertex_count;

  int mismatch_count;
  int visits_pending;
  int visits_checked;

  // stimulus-side knobs, read by the result sink
  bit no_idle        = 1'b0;  // both sides run without gaps
  bit hold_request   = 1'b0;  // ask the sink for one long stall
  bit hold_done      = 1'b0;

  int          edges_sent    = 0;
  int          walks_sent    = 0;
  int          counts_written = 0;
  int unsigned cycle_count   = 0;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  adjacency_matrix_dfs dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_visited_vertex (out_visited_vertex),
    .out_last_of_walk   (out_last_of_walk),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vertex_count   (cfg_vertex_count)
  );

  dfs_visit_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_visited_vertex (out_visited_vertex),
    .out_last_of_walk   (out_last_of_walk),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vertex_count   (cfg_vertex_count),
    .mismatch_count     (mismatch_count),
    .visits_pending     (visits_pending),
    .visits_checked     (visits_checked)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d visits still outstanding",
               cycle_count, visits_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink. Per result it draws a random gap with out_ready low,
  // then holds out_ready high until a transfer. When asked once, it instead
  // keeps out_ready low for HOLD_CYCLES so the result register and the command
  // queue fill up and in_ready drops while the sender keeps offering.
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // One command transfer: optional gap with valid low, then valid held with a
  // stable payload until in_ready. Called and returns on a rising edge.
  task automatic send_item(input logic cmd, input logic [VERTEX_W-1:0] a,
                           input logic [VERTEX_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_WALK) walks_sent++;
    else edges_sent++;
  endtask

  // Drop valid, let the checker see the last transfer, wait for every
  // predicted visit, then give a trailing edge command time to retire.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (visits_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // vertex_count is only changed with the engine idle
  task automatic write_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    counts_written++;
  endtask

  // Random phase at one vertex count. Mostly well-formed work: a random tree
  // over the live vertices followed by a walk, so walks reach deep. The rest
  // is noise: in-range edges (self loops included), edges anywhere in the
  // 6-bit field (mostly out of range at small counts), and bare walks.
  task automatic run_phase(input logic [COUNT_W-1:0] raw, input int budget);
    int n, sent, pick, k;
    write_count(raw);
    n    = (raw == 0) ? 1 : ((int'(raw) > MAXV) ? MAXV : int'(raw));
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 && n > 1) begin
        for (k = 1; k < n && sent < budget; k++) begin
          if ($urandom_range(0, 1))
            send_item(CMD_EDGE, VERTEX_W'(k), VERTEX_W'($urandom_range(0, k - 1)));
          else
            send_item(CMD_EDGE, VERTEX_W'($urandom_range(0, k - 1)), VERTEX_W'(k));
          sent++;
        end
        send_item(CMD_WALK, VERTEX_W'($urandom_range(0, 63)),
                  VERTEX_W'($urandom_range(0, 63)));
        sent++;
      end else if (pick < 7) begin
        send_item(CMD_EDGE, VERTEX_W'($urandom_range(0, n - 1)),
                  VERTEX_W'($urandom_range(0, n - 1)));
        sent++;
      end else if (pick < 8) begin
        send_item(CMD_EDGE, VERTEX_W'($urandom_range(0, 63)),
                  VERTEX_W'($urandom_range(0, 63)));
        sent++;
      end else begin
        send_item(CMD_WALK, VERTEX_W'($urandom_range(0, 63)),
                  VERTEX_W'($urandom_range(0, 63)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_EDGE;
    in_vertex_a      <= '0;
    in_vertex_b      <= '0;
    cfg_valid        <= 1'b0;
    cfg_vertex_count <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, reset count of 64; first transfer waits out the clear sweep
    send_item(CMD_WALK, 6'd0,  6'd0);    // empty graph: lone marked vertex 1
    send_item(CMD_EDGE, 6'd9,  6'd9);    // self loop, dropped
    send_item(CMD_EDGE, 6'd0,  6'd63);   // field extremes
    send_item(CMD_EDGE, 6'd63, 6'd1);
    send_item(CMD_EDGE, 6'd2,  6'd0);    // endpoints given high-then-low
    send_item(CMD_WALK, 6'd63, 6'd63);   // walk ignores its vertex fields

    write_count(7'd0);                   // acts as one vertex
    send_item(CMD_WALK, 6'd0,  6'd0);
    send_item(CMD_EDGE, 6'd0,  6'd1);    // beyond the live count, dropped
    send_item(CMD_WALK, 6'd21, 6'd42);

    write_count(7'd127);                 // clamps to 64, earlier edges still there
    send_item(CMD_EDGE, 6'd62, 6'd61);
    send_item(CMD_EDGE, 6'd61, 6'd63);
    send_item(CMD_WALK, 6'd0,  6'd0);

    write_count(7'd2);
    send_item(CMD_EDGE, 6'd0,  6'd2);    // endpoint equal to the count, dropped
    send_item(CMD_EDGE, 6'd1,  6'd0);
    send_item(CMD_WALK, 6'd0,  6'd0);    // all visited after two, early stop

    // --- random part over a spread of counts, edges accumulating across them
    run_phase(7'd5,  20);
    run_phase(7'd1,  6);
    run_phase(7'd8,  24);

    // Back-pressure burst: the sink stalls long after the first result while
    // back-to-back walks keep arriving, so the engine must stall its input.
    wait_idle();
    hold_request = 1'b1;
    no_idle      = 1'b1;
    repeat (12) send_item(CMD_WALK, VERTEX_W'($urandom_range(0, 63)),
                          VERTEX_W'($urandom_range(0, 63)));
    no_idle = 1'b0;

    run_phase(7'd64, 70);
    no_idle = 1'b1;                      // a gapless stretch on both sides
    run_phase(7'd3,  14);
    no_idle = 1'b0;
    run_phase(7'd16, 34);
    run_phase(7'd0,  6);
    run_phase(7'd2,  10);
    run_phase(7'd12, 26);
    run_phase(7'd100, 30);
    no_idle = 1'b1;
    run_phase(7'd32, 30);
    no_idle = 1'b0;

    wait_idle();

    $display("Run covered %0d edge commands and %0d walks over %0d vertex count settings,",
             edges_sent, walks_sent, counts_written);
    $display("with %0d visits compared and a %0d-cycle output stall during a walk burst.",
             visits_checked, HOLD_CYCLES);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/amdfs_pkg.sv
rtl/core/amdfs_ram.sv
rtl/core/amdfs_fifo.sv
rtl/core/amdfs_front.sv
rtl/core/amdfs_back.sv
rtl/core/adjacency_matrix_dfs.sv
rtl/core/amdfs_checker.sv
tb/sv/dfs_visit_checker.sv
tb/sv/tb_adjacency_matrix_dfs.sv
